[rtl/core/console_tx_byte_packer_core_macros.svh]
// ----------------------------------------------------------------------------
// Console transmit byte packer assertion macros
// Shared macros for the concurrent checks in the packer core.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_TX_BYTE_PACKER_CORE_MACROS_SVH
`define CONSOLE_TX_BYTE_PACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ctbp_pkg.sv]
// ----------------------------------------------------------------------------
// Console transmit byte packer package
// Shared constants, message types and helper functions.
// ----------------------------------------------------------------------------
package ctbp_pkg;

  localparam int unsigned FIFO_CAPACITY = 256;
  localparam int unsigned PACK_BYTES    = 8;
  localparam int unsigned LEVEL_W       = 9;
  localparam int unsigned SEEN_W        = LEVEL_W + 1;
  localparam int unsigned LEVEL_LIMIT   = FIFO_CAPACITY - 2;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [63:0] UPTIME_LIMIT_RST = 64'd100000000;
  localparam logic [7:0]  CH_LF            = 8'h0A;
  localparam logic [7:0]  CH_CR            = 8'h0D;
  localparam logic        KIND_PUT         = 1'b0;
  localparam logic        KIND_FLUSH       = 1'b1;

  typedef struct packed {
    logic        written;
    logic [3:0]  len;
    logic [63:0] data;
    logic        last;
  } msg_t;

  // Up to two messages pushed into the queue by one accepted transaction.
  typedef struct packed {
    logic [1:0] n;
    msg_t       m0;
    msg_t       m1;
  } push_t;

  // A message is kept only while the level it sees stays within the limit.
  function automatic logic fifo_has_room(input logic [LEVEL_W-1:0] level,
                                         input logic second);
    logic [SEEN_W-1:0] seen;
    seen = {1'b0, level} + (second ? SEEN_W'(2) : SEEN_W'(0));
    return (seen > SEEN_W'(LEVEL_LIMIT)) ? 1'b0 : 1'b1;
  endfunction

endpackage

[rtl/core/ctbp_front.sv]
// ----------------------------------------------------------------------------
// Console transmit byte packer front end
// Accepts transactions, keeps the packing state and builds the messages.
// ----------------------------------------------------------------------------
module ctbp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [87:0]                  in_tdata,
  input  logic                         in_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [63:0]                  cfg_data,
  input  logic                         q_room,
  output ctbp_pkg::push_t              push_o
);

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        dir;
    logic        emit;
    logic [3:0]  len;
    logic [63:0] data;
  } step_t;

  logic [63:0] limit_r;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        dir_r, dir_nxt;

  logic [7:0]                    ch;
  logic [63:0]                   uptime;
  logic [ctbp_pkg::LEVEL_W-1:0]  level;
  logic                          accept;
  logic                          late;
  logic                          cr_first;
  step_t                         s_a, s_b;
  ctbp_pkg::msg_t                msg_a, msg_b;
  logic [1:0]                    n_msg;

  // One character through the packing rules.
  function automatic step_t put_char(input logic [63:0] word, input logic [3:0] cnt,
                                     input logic dir, input logic [7:0] c,
                                     input logic over);
    step_t       s;
    logic [63:0] w;
    s = '0;
    w = word;
    if (dir) begin
      s.word = word;
      s.cnt  = cnt;
      s.dir  = 1'b1;
      s.emit = 1'b1;
      s.len  = 4'd1;
      s.data = {56'd0, c};
    end else begin
      for (int i = 0; i < ctbp_pkg::PACK_BYTES; i++) begin
        if (cnt == 4'(i)) begin
          w[8*i +: 8] = w[8*i +: 8] | c;
        end
      end
      s.cnt = cnt + 4'd1;
      s.dir = over;
      if (over || (s.cnt >= 4'(ctbp_pkg::PACK_BYTES))) begin
        s.emit = 1'b1;
        s.len  = s.cnt;
        s.data = w;
        s.word = '0;
        s.cnt  = '0;
      end else begin
        s.word = w;
      end
    end
    return s;
  endfunction

  assign ch        = in_tdata[7:0];
  assign uptime    = in_tdata[71:8];
  assign level     = in_tdata[80:72];
  assign in_tready = q_room;
  assign accept    = in_tvalid && q_room;
  assign cfg_ready = 1'b1;
  assign late      = uptime > limit_r;
  assign cr_first  = (ch == ctbp_pkg::CH_LF);

  always_comb begin
    s_a = '0;
    s_b = '0;
    if (in_tuser == ctbp_pkg::KIND_FLUSH) begin
      s_a.dir  = dir_r;
      s_a.emit = (cnt_r != 4'd0);
      s_a.len  = cnt_r;
      s_a.data = word_r;
      s_b.dir  = dir_r;
    end else begin
      s_a = put_char(word_r, cnt_r, dir_r, cr_first ? ctbp_pkg::CH_CR : ch, late);
      if (cr_first) begin
        s_b = put_char(s_a.word, s_a.cnt, s_a.dir, ch, late);
      end else begin
        s_b      = s_a;
        s_b.emit = 1'b0;
      end
    end
  end

  assign word_nxt = accept ? s_b.word : word_r;
  assign cnt_nxt  = accept ? s_b.cnt  : cnt_r;
  assign dir_nxt  = accept ? s_b.dir  : dir_r;

  // Messages are compacted so that the first emitted one always sits in slot 0.
  assign n_msg = 2'(s_a.emit) + 2'(s_b.emit);

  always_comb begin
    msg_a.written = ctbp_pkg::fifo_has_room(level, 1'b0);
    msg_a.len     = s_a.len;
    msg_a.data    = s_a.data;
    msg_a.last    = !s_b.emit;
    msg_b.written = ctbp_pkg::fifo_has_room(level, s_a.emit);
    msg_b.len     = s_b.len;
    msg_b.data    = s_b.data;
    msg_b.last    = 1'b1;
    push_o.n      = accept ? n_msg : 2'd0;
    push_o.m0     = s_a.emit ? msg_a : msg_b;
    push_o.m1     = msg_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ctbp_pkg::UPTIME_LIMIT_RST;
      word_r  <= '0;
      cnt_r   <= '0;
      dir_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
      dir_r  <= dir_nxt;
    end
  end

endmodule

[rtl/core/ctbp_queue.sv]
// ----------------------------------------------------------------------------
// Console transmit byte packer message queue
// Short queue taking up to two messages a cycle and giving one.
// ----------------------------------------------------------------------------
`include "console_tx_byte_packer_core_macros.svh"

module ctbp_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctbp_pkg::push_t        push_i,
  input  logic                   pop_i,
  output logic                   room_o,
  output logic                   nonempty_o,
  output ctbp_pkg::msg_t         head_o
);

  ctbp_pkg::msg_t                 mem_r [ctbp_pkg::QDEPTH];
  logic [ctbp_pkg::QPTR_W-1:0]    wr_r, wr_nxt;
  logic [ctbp_pkg::QPTR_W-1:0]    rd_r, rd_nxt;
  logic [ctbp_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic [ctbp_pkg::QPTR_W-1:0]    wr_plus1;

  assign wr_plus1   = wr_r + ctbp_pkg::QPTR_W'(1);
  assign room_o     = count_r <= ctbp_pkg::QCNT_W'(ctbp_pkg::QDEPTH - 2);
  assign nonempty_o = count_r != '0;
  assign head_o     = mem_r[rd_r];

  assign wr_nxt    = wr_r + ctbp_pkg::QPTR_W'(push_i.n);
  assign rd_nxt    = rd_r + ctbp_pkg::QPTR_W'(pop_i);
  assign count_nxt = count_r + ctbp_pkg::QCNT_W'(push_i.n) - ctbp_pkg::QCNT_W'(pop_i);

  always_ff @(posedge clk) begin
    if (push_i.n != 2'd0) begin
      mem_r[wr_r] <= push_i.m0;
    end
    if (push_i.n == 2'd2) begin
      mem_r[wr_plus1] <= push_i.m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  `CTBP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= ctbp_pkg::QCNT_W'(ctbp_pkg::QDEPTH), "queue count beyond depth")
  `CTBP_ASSERT_IMP(a_push_room, clk, rst_n, push_i.n != 2'd0, room_o, "push without room")
  `CTBP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop_i, count_r != '0, "pop from empty queue")
  `CTBP_ASSERT_NXT(a_pop_drain, clk, rst_n, pop_i && (push_i.n == 2'd0), count_r == $past(count_r) - ctbp_pkg::QCNT_W'(1), "pop did not drain one entry")

endmodule

[rtl/core/ctbp_back.sv]
// ----------------------------------------------------------------------------
// Console transmit byte packer back end
// Output register that presents queued messages on the result channel.
// ----------------------------------------------------------------------------
module ctbp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              nonempty_i,
  input  ctbp_pkg::msg_t    head_i,
  output logic              pop_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  logic           valid_r, valid_nxt;
  ctbp_pkg::msg_t msg_r;

  assign pop_o = nonempty_i && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop_o) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      msg_r <= head_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, msg_r.data, msg_r.len};
  assign out_tuser  = msg_r.written;
  assign out_tlast  = msg_r.last;

endmodule

[rtl/core/console_tx_byte_packer_core.sv]
// ----------------------------------------------------------------------------
// Console transmit byte packer core
// Turns console characters and flush requests into FIFO messages.
// ----------------------------------------------------------------------------
// Each input transaction carries either a character or a flush request (in_tuser),
// together with the current uptime and the transmit FIFO fill level. A newline is
// preceded by a carriage return. Early after reset, characters are packed into a
// 64-bit word, first character in the lowest byte, and sent as one message when
// eight are held, on a flush request, or when a character arrives after the uptime
// limit has passed; from then on every character goes out as its own message.
// Each result transaction reports the message, its length and whether it was
// written (out_tuser) or dropped because the FIFO was too full; out_tlast marks
// the final message caused by one input. An input may cause no result at all.
// The uptime limit is written on the cfg channel, which is always ready, and
// should only be written while the block is idle.
// Messages enter the queue and then the output register, which drives out_tvalid.
// An input is taken every cycle while the four-entry message queue has room for two
// messages; the output register drains one message per cycle while the receiver is
// ready. When the receiver stalls, the queue fills and in_tready falls.
// Synchronous reset clears the packing state, the queue and the output register,
// and restores the uptime limit to 100000000 ticks.
// ----------------------------------------------------------------------------
module console_tx_byte_packer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // character[7:0], uptime[71:8], fifo_level[80:72]
  input  logic        in_tuser,   // kind: 0 put character, 1 flush
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // msg_len[3:0], msg_data[67:4]
  output logic        out_tuser,  // written
  output logic        out_tlast,
  // Configuration channel for the uptime limit.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  ctbp_pkg::push_t push;
  ctbp_pkg::msg_t  head;
  logic            q_room;
  logic            q_nonempty;
  logic            q_pop;

  // The front end updates the packing state and pushes the finished messages.
  ctbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_room    (q_room),
    .push_o    (push)
  );

  // The queue decouples the two sides so that each may stall on its own.
  ctbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .pop_i      (q_pop),
    .room_o     (q_room),
    .nonempty_o (q_nonempty),
    .head_o     (head)
  );

  // The back end holds the message being offered to the receiver.
  ctbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .nonempty_i (q_nonempty),
    .head_i     (head),
    .pop_o      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
